### src/assert_macros.svh
// Assertion helpers shared by the RTL files.
// All of them sample on clk and stand down while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge.
`define ASSERT_ON_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that pre implies post in the same cycle.
`define ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Check that pre implies post in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### src/tis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_pkg
// Types and constants of the time indexed store search unit.
// ----------------------------------------------------------------------------
package tis_pkg;

  localparam int T_W   = 52;
  localparam int VAL_W = 64;
  localparam int FLG_W = 8;
  localparam int IDX_W = 11;
  localparam int IN_IDX_W = 10;
  localparam int ST_W  = 3;

  // input word layout, lowest bit up
  localparam int TREQ_LSB = 0;
  localparam int TEND_LSB = TREQ_LSB + T_W;
  localparam int TOL_LSB  = TEND_LSB + T_W;
  localparam int VAL_LSB  = TOL_LSB + T_W;
  localparam int FLG_LSB  = VAL_LSB + VAL_W;
  localparam int IIDX_LSB = FLG_LSB + FLG_W;
  localparam int IN_W     = 240;

  // output word layout, lowest bit up
  localparam int FND_LSB  = 0;
  localparam int END_LSB  = FND_LSB + IDX_W;
  localparam int ETM_LSB  = END_LSB + IDX_W;
  localparam int EVAL_LSB = ETM_LSB + T_W;
  localparam int EFLG_LSB = EVAL_LSB + VAL_W;
  localparam int CNT_LSB  = EFLG_LSB + FLG_W;
  localparam int SRT_LSB  = CNT_LSB + IDX_W;
  localparam int OUT_W    = 160;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_RANGE  = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_UNSORTED = 3'd2,
    ST_RANGE    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic [FLG_W-1:0] flg;
    logic [VAL_W-1:0] val;
    logic [T_W-1:0]   tm;
  } entry_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [T_W-1:0]      treq;
    logic [T_W-1:0]      tend;
    logic [T_W-1:0]      tol;
    logic [VAL_W-1:0]    val;
    logic [FLG_W-1:0]    flg;
    logic [IN_IDX_W-1:0] idx;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] found;
    logic [IDX_W-1:0] fin;
    entry_t           ent;
  } res_t;

  typedef enum logic [2:0] {
    ADDR_MID,
    ADDR_LO,
    ADDR_LAST,
    ADDR_IDX,
    ADDR_POSM1
  } addr_sel_t;

  typedef enum logic [3:0] {
    KIND_FULL,
    KIND_APPEND,
    KIND_READ,
    KIND_READ_ERR,
    KIND_FIND,
    KIND_UNSORTED,
    KIND_NOTFOUND,
    KIND_RANGE,
    KIND_BADRANGE
  } res_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_APP_WR,
    S_RD_CAP,
    S_SRCH_ADDR,
    S_SRCH_CMP,
    S_FIND_RC,
    S_FIND_LC,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic      load_in;
    logic      rd_en;
    addr_sel_t addr_sel;
    logic      wr_en;
    logic      srch_init;
    logic      srch_init2;
    logic      srch_step;
    logic      save_pos;
    logic      cap_right;
    logic      res_load;
    res_kind_t res_kind;
    logic      out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic empty;
    logic sorted;
    logic idx_oob;
    logic bad_range;
    logic srch_done;
    logic strict;
    logic out_free;
  } dp_stat_t;

endpackage

### src/tis_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_ram
// Simple dual port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/tis_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// tis_ctrl
// Command sequencer: decodes a word, steps the searches, hands off results.
// ----------------------------------------------------------------------------
module tis_ctrl
  import tis_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.cmd)
          CMD_APPEND: begin
            if (stat.full) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = KIND_FULL;
              state_next   = S_OUT;
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.addr_sel = ADDR_LAST;
              state_next   = S_APP_WR;
            end
          end
          CMD_FIND: begin
            if (!stat.sorted) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = KIND_UNSORTED;
              state_next   = S_OUT;
            end else if (stat.empty) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = KIND_NOTFOUND;
              state_next   = S_OUT;
            end else begin
              cmd.srch_init = 1'b1;
              state_next    = S_SRCH_ADDR;
            end
          end
          CMD_READ: begin
            if (stat.idx_oob) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = KIND_READ_ERR;
              state_next   = S_OUT;
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.addr_sel = ADDR_IDX;
              state_next   = S_RD_CAP;
            end
          end
          default: begin
            if (!stat.sorted) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = KIND_UNSORTED;
              state_next   = S_OUT;
            end else if (stat.bad_range) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = KIND_BADRANGE;
              state_next   = S_OUT;
            end else begin
              cmd.srch_init = 1'b1;
              state_next    = S_SRCH_ADDR;
            end
          end
        endcase
      end
      S_APP_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_kind = KIND_APPEND;
        state_next   = S_OUT;
      end
      S_RD_CAP: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = KIND_READ;
        state_next   = S_OUT;
      end
      S_SRCH_ADDR: begin
        if (!stat.srch_done) begin
          cmd.rd_en    = 1'b1;
          cmd.addr_sel = ADDR_MID;
          state_next   = S_SRCH_CMP;
        end else if (stat.cmd == CMD_FIND) begin
          // fetch the lower bound entry first, its left neighbor next
          cmd.save_pos = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.addr_sel = ADDR_LO;
          state_next   = S_FIND_RC;
        end else if (!stat.strict) begin
          // range: restart from the lower bound for the end time
          cmd.save_pos   = 1'b1;
          cmd.srch_init2 = 1'b1;
          state_next     = S_SRCH_ADDR;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_kind = KIND_RANGE;
          state_next   = S_OUT;
        end
      end
      S_SRCH_CMP: begin
        cmd.srch_step = 1'b1;
        state_next    = S_SRCH_ADDR;
      end
      S_FIND_RC: begin
        cmd.cap_right = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.addr_sel  = ADDR_POSM1;
        state_next    = S_FIND_LC;
      end
      S_FIND_LC: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = KIND_FIND;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ASSERT_IMPL(a_out_load_free, cmd.out_load, stat.out_free, "result loaded over a waiting word")
  `ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second word taken while busy")
  `ASSERT_NEXT(a_wr_then_out, cmd.wr_en, state == S_OUT, "append write not followed by result")

endmodule

### src/tis_dp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// tis_dp
// Datapath: entry store, fill count, sorted mark, search bounds, result regs.
// ----------------------------------------------------------------------------
module tis_dp
  import tis_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [IN_W-1:0]   s_tdata,
  input  logic [1:0]        s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,
  output logic [ST_W-1:0]   m_tuser,
  input  ctrl_cmd_t         cmd,
  output dp_stat_t          stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  in_t            in_q;
  logic [FW-1:0]  fill;
  logic           sorted;
  logic [FW-1:0]  lo;
  logic [FW-1:0]  hi;
  logic [FW-1:0]  pos;
  logic           strict;
  logic [T_W-1:0] tgt;
  entry_t         r_ent;
  logic [T_W-1:0] r_d;
  logic           r_ok;
  res_t           res;
  res_t           res_next;
  res_t           out_q;
  logic [IDX_W-1:0] cnt_q;
  logic           srt_q;

  logic [AW-1:0]  rd_addr;
  entry_t         rd_ent;
  entry_t         wr_ent;
  logic [FW:0]    mid_sum;
  logic [AW-1:0]  mid;
  logic           go_right;
  logic [T_W-1:0] d_right;
  logic [T_W-1:0] d_left;
  logic           l_ok;
  logic           full;

  assign full    = (fill == FW'(DEPTH));
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = AW'(mid_sum >> 1);

  always_comb begin
    case (cmd.addr_sel)
      ADDR_MID:   rd_addr = mid;
      ADDR_LO:    rd_addr = AW'(lo);
      ADDR_LAST:  rd_addr = AW'(fill - 1'b1);
      ADDR_IDX:   rd_addr = AW'(in_q.idx);
      ADDR_POSM1: rd_addr = AW'(pos - 1'b1);
      default:    rd_addr = mid;
    endcase
  end

  assign wr_ent.tm  = in_q.treq;
  assign wr_ent.val = in_q.val;
  assign wr_ent.flg = in_q.flg;

  tis_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (AW'(fill)),
    .wr_data (wr_ent),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_ent)
  );

  // capture the input word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_q.cmd  <= cmd_t'(s_tuser);
      in_q.treq <= s_tdata[TREQ_LSB +: T_W];
      in_q.tend <= s_tdata[TEND_LSB +: T_W];
      in_q.tol  <= s_tdata[TOL_LSB +: T_W];
      in_q.val  <= s_tdata[VAL_LSB +: VAL_W];
      in_q.flg  <= s_tdata[FLG_LSB +: FLG_W];
      in_q.idx  <= s_tdata[IIDX_LSB +: IN_IDX_W];
    end
  end

  // fill count and sorted mark
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      sorted <= 1'b1;
    end else if (cmd.wr_en) begin
      fill <= fill + 1'b1;
      if (sorted && (fill != '0) && (in_q.treq < rd_ent.tm)) begin
        sorted <= 1'b0;
      end
    end
  end

  // binary search bounds
  assign go_right = strict ? (rd_ent.tm <= tgt) : (rd_ent.tm < tgt);

  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      lo     <= '0;
      hi     <= fill;
      strict <= 1'b0;
      tgt    <= in_q.treq;
    end else if (cmd.srch_init2) begin
      hi     <= fill;
      strict <= 1'b1;
      tgt    <= in_q.tend;
    end else if (cmd.srch_step) begin
      if (go_right) begin
        lo <= FW'(mid) + 1'b1;
      end else begin
        hi <= FW'(mid);
      end
    end
    if (cmd.save_pos) begin
      pos <= lo;
    end
  end

  // nearest candidates around the lower bound
  assign d_right = rd_ent.tm - in_q.treq;
  assign d_left  = in_q.treq - rd_ent.tm;
  assign l_ok    = (pos != '0) && (d_left <= in_q.tol) && (!r_ok || (d_left < r_d));

  always_ff @(posedge clk) begin
    if (cmd.cap_right) begin
      r_ent <= rd_ent;
      r_d   <= d_right;
      r_ok  <= (pos < fill) && (d_right <= in_q.tol);
    end
  end

  always_comb begin
    res_next = '0;
    case (cmd.res_kind)
      KIND_FULL: begin
        res_next.status = ST_FULL;
      end
      KIND_APPEND: begin
        res_next.status = ST_OK;
        res_next.found  = IDX_W'(fill);
        res_next.ent    = wr_ent;
      end
      KIND_READ: begin
        res_next.status = ST_OK;
        res_next.found  = IDX_W'(in_q.idx);
        res_next.ent    = rd_ent;
      end
      KIND_READ_ERR: begin
        res_next.status = ST_RANGE;
      end
      KIND_FIND: begin
        if (l_ok) begin
          res_next.status = ST_OK;
          res_next.found  = IDX_W'(pos - 1'b1);
          res_next.ent    = rd_ent;
        end else if (r_ok) begin
          res_next.status = ST_OK;
          res_next.found  = IDX_W'(pos);
          res_next.ent    = r_ent;
        end else begin
          res_next.status = ST_NOTFOUND;
        end
      end
      KIND_UNSORTED: begin
        res_next.status = ST_UNSORTED;
      end
      KIND_NOTFOUND: begin
        res_next.status = ST_NOTFOUND;
      end
      KIND_RANGE: begin
        res_next.status = ST_OK;
        res_next.found  = IDX_W'(pos);
        res_next.fin    = IDX_W'(lo);
      end
      KIND_BADRANGE: begin
        res_next.status = ST_RANGE;
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res <= res_next;
    end
  end

  // output register, held until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_q <= res;
      cnt_q <= IDX_W'(fill);
      srt_q <= sorted;
    end
  end

  assign m_tuser = out_q.status;
  assign m_tdata = {2'b00, srt_q, cnt_q, out_q.ent.flg, out_q.ent.val, out_q.ent.tm,
                    out_q.fin, out_q.found};

  assign stat.cmd       = in_q.cmd;
  assign stat.full      = full;
  assign stat.empty     = (fill == '0);
  assign stat.sorted    = sorted;
  assign stat.idx_oob   = (32'(in_q.idx) >= 32'(fill));
  assign stat.bad_range = (in_q.tend < in_q.treq);
  assign stat.srch_done = !(lo < hi);
  assign stat.strict    = strict;
  assign stat.out_free  = !m_tvalid || m_tready;

  `ASSERT_ON_CLK(a_fill_bound, fill <= FW'(DEPTH), "fill count beyond depth")
  `ASSERT_IMPL(a_wr_not_full, cmd.wr_en, !full, "write into a full store")
  `ASSERT_IMPL(a_step_open, cmd.srch_step, lo < hi, "search step on an empty interval")
  `ASSERT_NEXT(a_unsorted_sticks, !sorted, !sorted, "sorted mark set again without reset")

endmodule

### src/time_indexed_store_nearest_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_indexed_store_nearest_search_unit
// Store of timestamped observations with append, read, nearest and range.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one command word: s_tuser holds the command
//   (append, find nearest, read, range) and s_tdata its operands. Each word
//   yields exactly one result word on the m_ channel: m_tuser holds the
//   status, m_tdata the indexes, the entry and the store state.
//   One word is worked at a time; s_tready is high only while the sequencer
//   is idle. A finished result sits in the output register while the next
//   word is already taken and worked.
//   A search takes at most clog2(DEPTH)+1 steps; each step reads the middle
//   entry on the single read port of the store, then compares it. A range
//   runs two searches back to back.
//   Reset empties the store and sets the sorted mark; entry contents are not
//   cleared, and an entry read beyond the fill count never decides a result.
//   When the receiver stalls, the result is held and one more word may be
//   worked; it then waits until the output register is taken.
// ----------------------------------------------------------------------------
module time_indexed_store_nearest_search_unit
  import tis_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // time_req[51:0], time_end[103:52], tolerance[155:104],
  // value_bits[219:156], flag[227:220], index[237:228], zero fill
  input  logic [IN_W-1:0]   s_tdata,
  // cmd[1:0]
  input  logic [1:0]        s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // found_index[10:0], end_index[21:11], entry_time[73:22],
  // entry_value[137:74], entry_flag[145:138], entry_count[156:146],
  // is_sorted[157], zero fill
  output logic [OUT_W-1:0]  m_tdata,
  // status[2:0]
  output logic [ST_W-1:0]   m_tuser
);

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  // sequencer: decode, search steps, result handoff
  tis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (ctl)
  );

  // store, bounds, compares and output register
  tis_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (ctl),
    .stat     (stat)
  );

endmodule

### dv/tis_store_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tis_store_checker
// Watches both channels of the store search unit, keeps its own copy of the
// store, predicts one result word per accepted command word and compares
// every result word with the oldest prediction.
// ----------------------------------------------------------------------------
module tis_store_checker
  import tis_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic [1:0]       s_tuser,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  input  logic [ST_W-1:0]  m_tuser,
  output int               mismatch_count,
  output int               awaited_count
);

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] found_idx;
    logic [IDX_W-1:0] end_idx;
    logic [T_W-1:0]   tm;
    logic [VAL_W-1:0] val;
    logic [FLG_W-1:0] flg;
    logic [IDX_W-1:0] count;
    logic             sorted;
  } outcome_t;

  logic [T_W-1:0]   stamp_mem [DEPTH];
  logic [VAL_W-1:0] value_mem [DEPTH];
  logic [FLG_W-1:0] flag_mem  [DEPTH];
  int               fill_n   = 0;
  logic             in_order = 1'b1;
  outcome_t         awaited_results[$];

  // First position at or after lo whose time is >= t, or > t when past_equal; fill_n if none.
  function automatic int locate_bound(int lo, logic [T_W-1:0] t, bit past_equal);
    int  hi;
    int  mid;
    bit  go_right;
    hi = fill_n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      go_right = past_equal ? (stamp_mem[mid] <= t) : (stamp_mem[mid] < t);
      if (go_right) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  function automatic outcome_t with_entry(outcome_t r, int i);
    r.found_idx = IDX_W'(i);
    r.tm        = stamp_mem[i];
    r.val       = value_mem[i];
    r.flg       = flag_mem[i];
    return r;
  endfunction

  // Advance the store copy by one command word and return its result.
  function automatic outcome_t apply_command(cmd_t c, logic [T_W-1:0] treq,
                                             logic [T_W-1:0] tend, logic [T_W-1:0] tol,
                                             logic [VAL_W-1:0] val, logic [FLG_W-1:0] flg,
                                             logic [IN_IDX_W-1:0] idx);
    outcome_t       r;
    int             pos;
    int             best;
    bit             have;
    logic [T_W-1:0] span;
    logic [T_W-1:0] best_span;
    int             lo_pos;
    r = '0;
    r.status = ST_OK;
    case (c)
      CMD_APPEND: begin
        if (fill_n >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (in_order && fill_n > 0 && treq < stamp_mem[fill_n-1]) in_order = 1'b0;
          stamp_mem[fill_n] = treq;
          value_mem[fill_n] = val;
          flag_mem[fill_n]  = flg;
          r = with_entry(r, fill_n);
          fill_n++;
        end
      end
      CMD_FIND: begin
        if (!in_order) begin
          r.status = ST_UNSORTED;
        end else if (fill_n == 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          pos       = locate_bound(0, treq, 1'b0);
          have      = 1'b0;
          best      = 0;
          best_span = '0;
          if (pos < fill_n) begin
            span = stamp_mem[pos] - treq;
            if (span <= tol) begin
              have      = 1'b1;
              best      = pos;
              best_span = span;
            end
          end
          // left neighbor wins only when strictly closer
          if (pos > 0) begin
            span = treq - stamp_mem[pos-1];
            if (span <= tol && (!have || span < best_span)) begin
              have = 1'b1;
              best = pos - 1;
            end
          end
          if (have) begin
            r = with_entry(r, best);
          end else begin
            r.status = ST_NOTFOUND;
          end
        end
      end
      CMD_READ: begin
        if (int'(idx) >= fill_n) begin
          r.status = ST_RANGE;
        end else begin
          r = with_entry(r, int'(idx));
        end
      end
      default: begin
        if (!in_order) begin
          r.status = ST_UNSORTED;
        end else if (tend < treq) begin
          r.status = ST_RANGE;
        end else begin
          lo_pos      = locate_bound(0, treq, 1'b0);
          r.found_idx = IDX_W'(lo_pos);
          r.end_idx   = IDX_W'(locate_bound(lo_pos, tend, 1'b1));
        end
      end
    endcase
    r.count  = IDX_W'(fill_n);
    r.sorted = in_order;
    return r;
  endfunction

  function automatic int field_differs(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v === act_v) return 0;
    $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
    return 1;
  endfunction

  // Pop before push so a result can never match the word taken at the same edge.
  always @(posedge clk) begin
    outcome_t want;
    int       errs;
    errs = 0;
    if (rst) begin
      fill_n   = 0;
      in_order = 1'b1;
      awaited_results.delete();
      mismatch_count <= 0;
      awaited_count  <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result word with no command word waiting, status %0d", m_tuser);
          errs++;
        end else begin
          want = awaited_results.pop_front();
          errs += field_differs("status", 64'(want.status), 64'(m_tuser));
          errs += field_differs("found_index", 64'(want.found_idx),
                                64'(m_tdata[FND_LSB +: IDX_W]));
          errs += field_differs("end_index", 64'(want.end_idx),
                                64'(m_tdata[END_LSB +: IDX_W]));
          errs += field_differs("entry_time", 64'(want.tm), 64'(m_tdata[ETM_LSB +: T_W]));
          errs += field_differs("entry_value", want.val, m_tdata[EVAL_LSB +: VAL_W]);
          errs += field_differs("entry_flag", 64'(want.flg),
                                64'(m_tdata[EFLG_LSB +: FLG_W]));
          errs += field_differs("entry_count", 64'(want.count),
                                64'(m_tdata[CNT_LSB +: IDX_W]));
          errs += field_differs("is_sorted", 64'(want.sorted), 64'(m_tdata[SRT_LSB]));
        end
      end
      if (s_tvalid && s_tready) begin
        awaited_results.insert(awaited_results.size(),
                               apply_command(cmd_t'(s_tuser),
                                             s_tdata[TREQ_LSB +: T_W],
                                             s_tdata[TEND_LSB +: T_W],
                                             s_tdata[TOL_LSB +: T_W],
                                             s_tdata[VAL_LSB +: VAL_W],
                                             s_tdata[FLG_LSB +: FLG_W],
                                             s_tdata[IIDX_LSB +: IN_IDX_W]));
      end
      mismatch_count <= mismatch_count + errs;
      awaited_count  <= awaited_results.size();
    end
  end

endmodule

### dv/time_indexed_store_nearest_search_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_indexed_store_nearest_search_unit_tb
// Drives command words into the store search unit and gives the verdict.
// A short directed pass covers the empty store, ties, exact hits, empty and
// reversed ranges; a long random pass keeps the store in time order while
// mixing appends, finds, ranges and reads around stored times; a last pass
// breaks the order, fills the store and appends past full. Prediction and
// comparison live in tis_store_checker.
// ----------------------------------------------------------------------------
module time_indexed_store_nearest_search_unit_tb;
  import tis_pkg::*;

  localparam int DEPTH        = 1024;
  localparam int SORTED_ITEMS = 300;
  // watchdog limit on cycles with no word moving on either channel
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 120;
  localparam logic [T_W-1:0] T_MAX = '1;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata  = '0;
  logic [1:0]        s_tuser  = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic [ST_W-1:0]   m_tuser;

  int                mismatches;
  int                awaited_n;
  int                quiet_cycles = 0;
  bit                send_calm    = 1'b0;
  // times appended so far, in store order; used only to aim the stimulus
  logic [T_W-1:0]    stamps[$];

  always #5 clk = ~clk;

  time_indexed_store_nearest_search_unit #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  tis_store_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .mismatch_count(mismatches),
    .awaited_count (awaited_n)
  );

  // Watchdog: end the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: a random stall before each result word, with calm stretches that have none.
  initial begin
    int stall;
    bit calm;
    calm = 1'b0;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  function automatic logic [T_W-1:0] days(int n);
    return T_W'(n) << 32;
  endfunction

  function automatic logic [T_W-1:0] any_time();
    return T_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [VAL_W-1:0] any_value();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [FLG_W-1:0] any_flag();
    return FLG_W'($urandom());
  endfunction

  function automatic logic [IN_IDX_W-1:0] any_index();
    return IN_IDX_W'($urandom());
  endfunction

  // Offer one command word after a random gap and hold it until taken.
  task automatic send_word(cmd_t c, logic [T_W-1:0] treq, logic [T_W-1:0] tend,
                           logic [T_W-1:0] tol, logic [IN_IDX_W-1:0] idx,
                           logic [VAL_W-1:0] val, logic [FLG_W-1:0] flg);
    int gap;
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= {2'b00, idx, flg, val, tol, tend, treq};
    do @(posedge clk); while (!s_tready);
    if (c == CMD_APPEND && stamps.size() < DEPTH) stamps.insert(stamps.size(), treq);
  endtask

  // Drop valid and hold off until every result word has come back.
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_n != 0);
  endtask

  // Find aimed at a stored time: exact hits, near misses, midpoints for ties.
  task automatic send_find_near();
    int             i;
    logic [T_W-1:0] off;
    logic [T_W-1:0] target;
    logic [T_W-1:0] tol;
    i   = $urandom_range(0, stamps.size() - 1);
    off = ($urandom_range(0, 3) == 0) ? T_W'($urandom()) : T_W'($urandom_range(0, 1000));
    case ($urandom_range(0, 3))
      0: target = stamps[i];
      1: target = (stamps[i] >= off) ? stamps[i] - off : stamps[i] + off;
      2: target = stamps[i] + off;
      default: begin
        if (i + 1 < stamps.size()) begin
          target = stamps[i] + (stamps[i+1] - stamps[i]) / 2;
        end else begin
          target = stamps[i];
        end
      end
    endcase
    case ($urandom_range(0, 4))
      0: tol = '0;
      1: tol = off;
      2: tol = T_W'($urandom_range(0, 1000));
      3: tol = any_time();
      default: tol = T_MAX;
    endcase
    send_word(CMD_FIND, target, any_time(), tol, any_index(), any_value(), any_flag());
  endtask

  // Range between two stored times, nudged outward, sometimes reversed.
  task automatic send_range_near();
    int             i;
    int             j;
    int             k;
    logic [T_W-1:0] lo_t;
    logic [T_W-1:0] hi_t;
    i = $urandom_range(0, stamps.size() - 1);
    j = $urandom_range(0, stamps.size() - 1);
    if (i > j) begin
      k = i;
      i = j;
      j = k;
    end
    lo_t = stamps[i];
    hi_t = stamps[j];
    if ($urandom_range(0, 2) == 0 && lo_t > 0) lo_t = lo_t - 1;
    if ($urandom_range(0, 2) == 0) hi_t = hi_t + T_W'($urandom_range(0, 1000));
    if ($urandom_range(0, 7) == 0) begin
      send_word(CMD_RANGE, hi_t, lo_t, any_time(), any_index(), any_value(), any_flag());
    end else begin
      send_word(CMD_RANGE, lo_t, hi_t, any_time(), any_index(), any_value(), any_flag());
    end
  endtask

  // Any command but append, with every field random.
  task automatic send_noise();
    send_word(cmd_t'($urandom_range(CMD_FIND, CMD_RANGE)), any_time(), any_time(), any_time(),
              any_index(), any_value(), any_flag());
  endtask

  initial begin
    int             pick;
    logic [T_W-1:0] step;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // --- directed: empty store ---
    send_word(CMD_FIND,  days(5),  '0,      T_MAX, '0, '0, '0);  // nothing to find
    send_word(CMD_RANGE, '0,       T_MAX,   '0,    '0, '0, '0);  // empty range on empty store
    send_word(CMD_RANGE, days(10), days(5), '0,    '0, '0, '0);  // end before start
    send_word(CMD_READ,  '0,       '0,      '0,    '0, '0, '0);  // read past fill

    // --- directed: four entries, last two share a time ---
    send_word(CMD_APPEND, '0,       '0, '0, '0, '1,          '1);
    send_word(CMD_APPEND, days(10), '0, '0, '0, '0,          '0);
    send_word(CMD_APPEND, days(20), '0, '0, '0, any_value(), any_flag());
    send_word(CMD_APPEND, days(20), '0, '0, '0, any_value(), any_flag());

    // equal distance both sides: right entry wins
    send_word(CMD_FIND, days(15), '0, days(5),     '0, '0, '0);
    // one short of reaching either side
    send_word(CMD_FIND, days(15), '0, days(5) - 1, '0, '0, '0);
    send_word(CMD_FIND, '0,       '0, '0,          '0, '0, '0);  // exact hit, zero tolerance
    send_word(CMD_FIND, T_MAX,    '0, T_MAX,       '0, '0, '0);  // beyond last entry
    send_word(CMD_FIND, days(12), '0, T_MAX,       '0, '0, '0);  // left side closer

    send_word(CMD_RANGE, days(10), days(20), '0, '0, '0, '0);
    send_word(CMD_RANGE, days(21), days(30), '0, '0, '0, '0);    // no entries inside
    send_word(CMD_RANGE, days(10), days(10), '0, '0, '0, '0);    // single point
    send_word(CMD_RANGE, '0,       T_MAX,    '0, '0, '0, '0);

    send_word(CMD_READ, '0, '0, '0, 10'd3, '0, '0);
    send_word(CMD_READ, '0, '0, '0, 10'd4, '0, '0);
    send_word(CMD_READ, '0, '0, '0, '1,    '0, '0);

    hold_until_drained();

    // --- random, store kept in time order ---
    for (int n = 0; n < SORTED_ITEMS; n++) begin
      if (n == SORTED_ITEMS / 2) hold_until_drained();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // repeat the last time now and then, else advance up to four days
        step = ($urandom_range(0, 7) == 0) ? '0 : T_W'({$urandom_range(0, 3), $urandom()});
        send_word(CMD_APPEND, stamps[$] + step, any_time(), any_time(), any_index(),
                  any_value(), any_flag());
      end else if (pick < 85) begin
        if ($urandom_range(0, 9) == 0) begin
          send_word(CMD_FIND, any_time(), any_time(), any_time(), any_index(),
                    any_value(), any_flag());
        end else begin
          send_find_near();
        end
      end else if (pick < 93) begin
        if ($urandom_range(0, 9) == 0) begin
          send_word(CMD_RANGE, any_time(), any_time(), any_time(), any_index(),
                    any_value(), any_flag());
        end else begin
          send_range_near();
        end
      end else begin
        send_word(CMD_READ, any_time(), any_time(), any_time(),
                  ($urandom_range(0, 3) == 0) ? any_index()
                                              : IN_IDX_W'($urandom_range(0, stamps.size() - 1)),
                  any_value(), any_flag());
      end
    end

    hold_until_drained();

    // --- break the time order; find and range now report unsorted ---
    send_word(CMD_APPEND, stamps[$] - 1, '0, '0, '0, any_value(), any_flag());
    send_word(CMD_FIND,   stamps[0], '0, T_MAX, '0, '0, '0);
    send_word(CMD_RANGE,  days(10), days(5), '0, '0, '0, '0);  // unsorted beats bad range
    send_word(CMD_RANGE,  '0, T_MAX, '0, '0, '0, '0);
    send_word(CMD_APPEND, T_MAX, '0, '0, '0, any_value(), any_flag());

    // --- fill the store with random times ---
    while (stamps.size() < DEPTH) begin
      if ($urandom_range(0, 99) < 97) begin
        send_word(CMD_APPEND, any_time(), any_time(), any_time(), any_index(),
                  any_value(), any_flag());
      end else begin
        send_noise();
      end
    end

    // --- full store: appends drop, last slot still readable ---
    repeat (3) begin
      send_word(CMD_APPEND, any_time(), any_time(), any_time(), any_index(),
                any_value(), any_flag());
    end
    send_word(CMD_READ, '0, '0, '0, '1, '0, '0);
    send_word(CMD_READ, '0, '0, '0, '0, '0, '0);
    repeat (20) send_noise();

    // drain, then give the unit time to show any stray word
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_n == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/tis_pkg.sv
src/tis_ram.sv
src/tis_ctrl.sv
src/tis_dp.sv
src/time_indexed_store_nearest_search_unit.sv
dv/tis_store_checker.sv
dv/time_indexed_store_nearest_search_unit_tb.sv
